// File: hw/rtl/lcdsw_pkg.sv
// ----------------------------------------------------------------------------
// lcdsw_pkg
// Shared types and constants for the three-wire segment LCD write serializer.
// ----------------------------------------------------------------------------
package lcdsw_pkg;

  // Field widths of the item ports
  localparam int ReqTypeW = 3;
  localparam int AddrInW  = 6;
  localparam int PayloadW = 8;

  // Default width of the address sent on the line
  localparam int AddrBitsDefault = 6;

  // Frame ids, sent MSB first
  localparam int IdW = 3;
  localparam logic [IdW-1:0] IdCommand = 3'b100;
  localparam logic [IdW-1:0] IdWrite   = 3'b101;

  // Command frame: id, eight command bits, one pad bit
  localparam int CmdFrameBits = IdW + PayloadW + 1;
  localparam int NibbleBits   = 4;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_COMMAND     = 3'd0,
    REQ_SINGLE      = 3'd1,
    REQ_BURST_OPEN  = 3'd2,
    REQ_BURST_BYTE  = 3'd3,
    REQ_BURST_CLOSE = 3'd4
  } req_e;

  // Control part of a formatted frame
  typedef struct packed {
    logic lead_release;  // one select-release result ahead of the bits
    logic bad;           // lone error result, no bits
    logic burst_next;    // burst state after this item
  } frame_ctl_t;

endpackage

// File: hw/rtl/lcd_segment_serial_writer_core.sv
// ----------------------------------------------------------------------------
// lcd_segment_serial_writer_core
// Serializer for a three-wire segment LCD controller: each request item
// becomes a run of result items, one line bit, select release or error per item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o| req_type_i, ram_address_i,
//           |           |                        | payload_i
//   out     | output    | out_valid_o/out_stall_i| data_bit_o, select_active_o,
//           |           |                        | strobe_valid_o, bad_request_o,
//           |           |                        | last_of_run_o
//
// A request gives up to 1 + 3 + ADDR_BITS + 4 result items (14 at the default),
//   or 1 + 12 if the command frame is longer; the frame shift register gives
//   out one bit per cycle while out_stall_i is low.
// One request is in flight at a time; in_stall_o is high until its last
//   result has been taken. Unused request codes are taken and give no results.
// Reset clears the burst flag and the run counters; no results pending.
// out_stall_i holds the current result; the shift register waits with it.
// ----------------------------------------------------------------------------
module lcd_segment_serial_writer_core #(
  parameter int ADDR_BITS = lcdsw_pkg::AddrBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lcdsw_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [lcdsw_pkg::AddrInW-1:0]  ram_address_i,
  input  logic [lcdsw_pkg::PayloadW-1:0] payload_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           data_bit_o,
  output logic                           select_active_o,
  output logic                           strobe_valid_o,
  output logic                           bad_request_o,
  output logic                           last_of_run_o
);
  import lcdsw_pkg::*;

  // Frame is long enough for a command frame and for a single write frame
  localparam int FrameW = (IdW + ADDR_BITS + NibbleBits > CmdFrameBits) ?
                          (IdW + ADDR_BITS + NibbleBits) : CmdFrameBits;
  localparam int CntW   = $clog2(FrameW + 1);

  // Run state: an optional release result, then either one error result or
  // cnt_q line bits taken from the top of sr_q.
  logic              rel_q, rel_d;
  logic              bad_q, bad_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FrameW-1:0] sr_q, sr_d;
  logic              burst_q, burst_d;

  logic              busy;
  logic              in_acc;
  logic              out_acc;
  logic              bit_phase;   // current result is a line bit

  logic [FrameW-1:0] frame_bits;
  logic [CntW-1:0]   frame_len;
  frame_ctl_t        frame_ctl;

  lcdsw_frame_build #(
    .ADDR_BITS(ADDR_BITS)
  ) u_frame_build (
    .req_type_i   (req_type_i),
    .ram_address_i(ram_address_i),
    .payload_i    (payload_i),
    .burst_open_i (burst_q),
    .bits_o       (frame_bits),
    .len_o        (frame_len),
    .ctl_o        (frame_ctl)
  );

  assign busy      = rel_q | bad_q | (cnt_q != '0);
  assign in_stall_o  = busy;
  assign out_valid_o = busy;
  assign in_acc    = in_valid_i & ~busy;
  assign out_acc   = busy & ~out_stall_i;
  assign bit_phase = ~rel_q & ~bad_q;

  // Result fields straight from the run registers
  assign data_bit_o      = bit_phase & sr_q[FrameW-1];
  assign select_active_o = bit_phase;
  assign strobe_valid_o  = bit_phase;
  assign bad_request_o   = ~rel_q & bad_q;
  always_comb begin
    if (rel_q) begin
      last_of_run_o = ~bad_q & (cnt_q == '0);
    end else if (bad_q) begin
      last_of_run_o = 1'b1;
    end else begin
      last_of_run_o = (cnt_q == CntW'(1));
    end
  end

  always_comb begin
    rel_d   = rel_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    sr_d    = sr_q;
    burst_d = burst_q;
    if (in_acc) begin
      rel_d   = frame_ctl.lead_release;
      bad_d   = frame_ctl.bad;
      cnt_d   = frame_len;
      sr_d    = frame_bits;
      burst_d = frame_ctl.burst_next;
    end else if (out_acc) begin
      if (rel_q) begin
        rel_d = 1'b0;
      end else if (bad_q) begin
        bad_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CntW'(1);
        sr_d  = sr_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q   <= 1'b0;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
      burst_q <= 1'b0;
    end else begin
      rel_q   <= rel_d;
      bad_q   <= bad_d;
      cnt_q   <= cnt_d;
      burst_q <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // an error result stands alone, with select released
  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_request_o |-> !select_active_o && last_of_run_o)
    else $error("error result not alone");

  // taking the last result of a run leaves the block idle
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_of_run_o |=> !out_valid_o)
    else $error("results after end of run");

  // a burst byte inside a burst starts with a line bit
  a_burst_byte_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_BURST_BYTE && burst_q
    |=> out_valid_o && strobe_valid_o && !bad_request_o)
    else $error("burst byte did not start a bit run");

  // a burst close always ends with the burst flag clear
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_BURST_CLOSE
    |=> !burst_q && out_valid_o && !select_active_o)
    else $error("burst close did not release");

endmodule

// File: hw/rtl/lcdsw_frame_build.sv
// ----------------------------------------------------------------------------
// lcdsw_frame_build
// Formats one request into a left-aligned bit frame, its length, and the
// control flags for the serializer.
// ----------------------------------------------------------------------------
module lcdsw_frame_build #(
  parameter int ADDR_BITS = lcdsw_pkg::AddrBitsDefault,
  localparam int FrameW = (lcdsw_pkg::IdW + ADDR_BITS + lcdsw_pkg::NibbleBits >
                           lcdsw_pkg::CmdFrameBits) ?
                          (lcdsw_pkg::IdW + ADDR_BITS + lcdsw_pkg::NibbleBits) :
                          lcdsw_pkg::CmdFrameBits,
  localparam int CntW = $clog2(FrameW + 1)
) (
  input  logic [lcdsw_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [lcdsw_pkg::AddrInW-1:0]  ram_address_i,
  input  logic [lcdsw_pkg::PayloadW-1:0] payload_i,
  input  logic                           burst_open_i,
  output logic [FrameW-1:0]              bits_o,
  output logic [CntW-1:0]                len_o,
  output lcdsw_pkg::frame_ctl_t          ctl_o
);
  import lcdsw_pkg::*;

  localparam int WrBits   = IdW + ADDR_BITS + NibbleBits;
  localparam int OpenBits = IdW + ADDR_BITS;

  logic [ADDR_BITS-1:0]  addr;
  logic [NibbleBits-1:0] nib_rev;
  logic [PayloadW-1:0]   pay_rev;
  req_e                  req;

  assign addr = ADDR_BITS'(ram_address_i);
  assign req  = req_e'(req_type_i);

  // LSB-first fields go out of the top of the frame, so reverse them here
  always_comb begin
    for (int i = 0; i < PayloadW; i++) begin
      pay_rev[i] = payload_i[PayloadW-1-i];
    end
    for (int i = 0; i < NibbleBits; i++) begin
      nib_rev[i] = payload_i[NibbleBits-1-i];
    end
  end

  always_comb begin
    bits_o = '0;
    len_o  = '0;
    ctl_o  = '{lead_release: 1'b0, bad: 1'b0, burst_next: burst_open_i};
    case (req)
      REQ_COMMAND: begin
        bits_o = FrameW'({IdCommand, payload_i, 1'b0}) << (FrameW - CmdFrameBits);
        len_o  = CntW'(CmdFrameBits);
        ctl_o.lead_release = burst_open_i;
        ctl_o.burst_next   = 1'b0;
      end
      REQ_SINGLE: begin
        bits_o = FrameW'({IdWrite, addr, nib_rev}) << (FrameW - WrBits);
        len_o  = CntW'(WrBits);
        ctl_o.lead_release = burst_open_i;
        ctl_o.burst_next   = 1'b0;
      end
      REQ_BURST_OPEN: begin
        bits_o = FrameW'({IdWrite, addr}) << (FrameW - OpenBits);
        len_o  = CntW'(OpenBits);
        ctl_o.lead_release = burst_open_i;
        ctl_o.burst_next   = 1'b1;
      end
      REQ_BURST_BYTE: begin
        if (burst_open_i) begin
          bits_o = FrameW'(pay_rev) << (FrameW - PayloadW);
          len_o  = CntW'(PayloadW);
        end else begin
          ctl_o.bad = 1'b1;
        end
      end
      REQ_BURST_CLOSE: begin
        ctl_o.lead_release = 1'b1;
        ctl_o.burst_next   = 1'b0;
      end
      default: begin
        // unused codes: no results, burst state kept
      end
    endcase
  end

endmodule
